// ----- hdl/blr_pkg.sv -----
// Shared types and constants for the line rasterizer.
`default_nettype none
package blr_pkg;

	localparam int CoordW  = 6;
	localparam int ColorW  = 24;
	localparam int SideW   = 7;
	localparam int AddrW   = 12;
	localparam int ErrW    = 10;
	localparam int CfgIdxW = 1;
	localparam int QDepth  = 2;
	localparam int QPtrW   = 1;
	localparam int QCntW   = 2;

	// largest usable image side; register values above it saturate
	localparam logic [SideW-1:0] MAX_SIDE = 7'd64;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// one classified line, ready for the stepper
	typedef struct packed {
		logic [CoordW-1:0] maj;
		logic [CoordW-1:0] min;
		logic [CoordW-1:0] dmaj;
		logic [CoordW-1:0] dmin;
		logic              maj_down;
		logic              min_down;
		logic              steep;
		logic [ErrW-1:0]   err;
		logic [ColorW-1:0] color;
	} job_t;

endpackage
`default_nettype wire

// ----- hdl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer.
`default_nettype none
// Each line command on the slave stream becomes one pixel word per step of its
// major axis; the end point is not drawn and a zero-length line yields nothing.
// The front end classifies a command in the cycle it is taken and hands it to
// a two-entry queue, so up to two lines wait while one is drawn. The stepper
// loads a line from the queue and then walks it with a single error accumulator,
// emitting one pixel per cycle while m_tready does not hold the output back.
// Image width and height are written through the cfg port; the user must write
// them only while the block is idle (the block does not enforce it); values above
// 64 count as 64. Pixels outside the image come out with tuser low and address zero.
module bresenham_line_rasterizer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], line_color[47:24]
	input  wire logic [47:0]                   s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// pixel_x[5:0], pixel_y[11:6], write_address[23:12], pixel_color[47:24]
	output logic [47:0]                        m_tdata,
	// in_bounds[0]
	output logic                               m_tuser,
	// last_pixel
	output logic                               m_tlast,
	input  wire logic                          cfg_write,
	input  wire logic [blr_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [blr_pkg::SideW-1:0]     cfg_data
);
	import blr_pkg::*;

	logic [SideW-1:0] width_q, height_q;
	logic [SideW-1:0] width_c, height_c;
	logic             q_push, q_pop, q_full, q_empty;
	job_t             push_job, head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate to the largest supported side
	assign width_c  = (width_q  > MAX_SIDE) ? MAX_SIDE : width_q;
	assign height_c = (height_q > MAX_SIDE) ? MAX_SIDE : height_q;

	blr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	blr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	blr_stepper u_stepper (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_job    (head_job),
		.q_pop    (q_pop),
		.width    (width_c),
		.height   (height_c),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ----- hdl/blr_front.sv -----
// Command front end: takes line commands, works out extents, axis and error seed.
`default_nettype none
module blr_front (
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [47:0]           s_tdata,
	input  wire logic                  q_full,
	output logic                       q_push,
	output blr_pkg::job_t              q_job
);
	import blr_pkg::*;

	logic [CoordW-1:0] x0, y0, x1, y1;
	logic [CoordW-1:0] dx, dy;
	logic              x_up, y_up, steep;

	assign x0 = s_tdata[5:0];
	assign y0 = s_tdata[11:6];
	assign x1 = s_tdata[17:12];
	assign y1 = s_tdata[23:18];

	assign x_up  = x1 > x0;
	assign y_up  = y1 > y0;
	assign dx    = x_up ? x1 - x0 : x0 - x1;
	assign dy    = y_up ? y1 - y0 : y0 - y1;
	assign steep = dy > dx;

	always_comb begin
		q_job.steep    = steep;
		q_job.maj      = steep ? y0 : x0;
		q_job.min      = steep ? x0 : y0;
		q_job.dmaj     = steep ? dy : dx;
		q_job.dmin     = steep ? dx : dy;
		q_job.maj_down = steep ? !y_up : !x_up;
		q_job.min_down = steep ? !x_up : !y_up;
		q_job.color    = s_tdata[47:24];
		q_job.err      = {{(ErrW-CoordW-1){1'b0}}, q_job.dmin, 1'b0}
			- {{(ErrW-CoordW){1'b0}}, q_job.dmaj};
	end

	assign s_tready = !q_full;
	// drop zero-length lines here: they produce no pixels
	assign q_push   = s_tvalid && s_tready && (q_job.dmaj != '0);

endmodule
`default_nettype wire

// ----- hdl/blr_queue.sv -----
// Two-entry queue of classified lines between front end and stepper.
`default_nettype none
module blr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire blr_pkg::job_t push_job,
	input  wire logic          pop,
	output blr_pkg::job_t      head_job,
	output logic               full,
	output logic               empty
);
	import blr_pkg::*;

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full     = count_q == QCntW'(QDepth);
	assign empty    = count_q == '0;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ----- hdl/blr_stepper.sv -----
// Back end: walks the major axis one pixel a cycle while the output is not stalled, and registers each pixel word.
`default_nettype none
module blr_stepper (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_empty,
	input  wire blr_pkg::job_t               q_job,
	output logic                             q_pop,
	input  wire logic [blr_pkg::SideW-1:0]   width,
	input  wire logic [blr_pkg::SideW-1:0]   height,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [47:0]                      m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import blr_pkg::*;

	logic              busy_q;
	job_t              job_q;
	logic [CoordW-1:0] cnt_q;

	logic              out_valid_q;
	logic [CoordW-1:0] out_x_q, out_y_q;
	logic [AddrW-1:0]  out_addr_q;
	logic [ColorW-1:0] out_color_q;
	logic              out_in_q, out_last_q;

	logic              step;
	logic [CoordW-1:0] px, py;
	logic              in_img;
	logic [SideW+CoordW-1:0] prod;
	logic [AddrW-1:0]  addr;
	logic              err_pos;
	logic [ErrW-1:0]   err_next;

	assign q_pop = !busy_q && !q_empty;
	assign step  = busy_q && (!out_valid_q || m_tready);

	assign px      = job_q.steep ? job_q.min : job_q.maj;
	assign py      = job_q.steep ? job_q.maj : job_q.min;
	assign in_img  = ({1'b0, px} < width) && ({1'b0, py} < height);
	assign prod    = py * width;
	assign addr    = in_img ? prod[AddrW-1:0] + AddrW'(px) : '0;
	assign err_pos = !job_q.err[ErrW-1];

	always_comb begin
		err_next = job_q.err + {{(ErrW-CoordW-1){1'b0}}, job_q.dmin, 1'b0};
		if (err_pos) begin
			err_next = err_next - {{(ErrW-CoordW-1){1'b0}}, job_q.dmaj, 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end else if (step) begin
			job_q.maj <= job_q.maj_down ? job_q.maj - 1'b1 : job_q.maj + 1'b1;
			if (err_pos) begin
				job_q.min <= job_q.min_down ? job_q.min - 1'b1 : job_q.min + 1'b1;
			end
			job_q.err <= err_next;
		end
		if (step) begin
			out_x_q     <= px;
			out_y_q     <= py;
			out_addr_q  <= addr;
			out_color_q <= job_q.color;
			out_in_q    <= in_img;
			out_last_q  <= cnt_q == CoordW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				cnt_q  <= q_job.dmaj;
			end else if (step) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CoordW'(1)) begin
					busy_q <= 1'b0;
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_color_q, out_addr_q, out_y_q, out_x_q};
	assign m_tuser  = out_in_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("stepper busy with no pixels left");
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		step && cnt_q == CoordW'(1) |=> !busy_q && out_valid_q && out_last_q)
		else $error("final pixel did not close the line");
	a_clip_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_in_q |-> out_addr_q == '0)
		else $error("clipped pixel carries an address");
`endif

endmodule
`default_nettype wire
